[hdl/ppi_pkg.sv]
`default_nettype none
package ppi_pkg;

    // Palette geometry
    localparam int MAX_COLORS  = 4096;
    localparam int SLOT_COUNT  = 2 * MAX_COLORS;
    localparam int IDX_W       = 12;
    localparam int SLOT_W      = 13;
    localparam int COUNT_W     = 13;
    localparam int COLOR_W     = 25;

    // Low bits of the Fibonacci hash multiplier 2654435761
    localparam logic [SLOT_W-1:0] HASH_MULT = 13'h19B1;

    // Base-91 code: floor(x / 91) = (x * DIV_RECIP) >> DIV_SHIFT for x < 4096
    localparam int CODE_RADIX  = 91;
    localparam logic [13:0] DIV_RECIP = 14'd11523;
    localparam int DIV_SHIFT   = 20;

    localparam logic [8*CODE_RADIX-1:0] DIGITS =
        {" .#abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789",
         "!$%&'()*+,-:;<=>@[]^_`{|}~"};

    typedef enum logic [1:0] {
        OP_LEARN  = 2'd0,
        OP_ENCODE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_ABSENT = 2'd2,
        STS_RANGE  = 2'd3
    } sts_t;

    typedef enum logic [2:0] {
        RES_LEARN_HIT = 3'd0,
        RES_ENC_HIT   = 3'd1,
        RES_NEW       = 3'd2,
        RES_FULL      = 3'd3,
        RES_ABSENT    = 3'd4,
        RES_READ      = 3'd5,
        RES_RANGE     = 3'd6,
        RES_CLEAR     = 3'd7
    } kind_t;

    typedef struct packed {
        logic  capture;
        logic  set_pos;
        logic  step_pos;
        logic  pal_from_slot;
        logic  insert;
        logic  hit;
        logic  load_res;
        logic  sweep;
        logic  count_clear;
        kind_t res_kind;
    } cmd_t;

    typedef struct packed {
        logic slot_empty;
        logic pal_match;
        logic count_full;
        logic range_bad;
        logic probe_end;
        logic sweep_last;
        logic res_free;
        op_t  op;
        op_t  in_op;
    } stat_t;

    // ASCII of one base-91 digit
    function automatic logic [7:0] digit_char(input logic [6:0] d);
        int pos;
        pos = (CODE_RADIX - 1 - int'(d)) * 8;
        return DIGITS[pos +: 8];
    endfunction

endpackage
`default_nettype wire

[hdl/ppi_ctrl.sv]
`default_nettype none
module ppi_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire ppi_pkg::stat_t stat,
    output ppi_pkg::cmd_t       cmd
);

    typedef enum logic [8:0] {
        S_SWEEP = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_HASH  = 9'b000000100,
        S_SLOT  = 9'b000001000,
        S_CHECK = 9'b000010000,
        S_MATCH = 9'b000100000,
        S_CODE  = 9'b001000000,
        S_RDPAL = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    ppi_pkg::kind_t  kind_reg, kind_next;

    // Advance state and hold the result kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            kind_reg  <= ppi_pkg::RES_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // Decode state into datapath commands
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.res_kind = kind_reg;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (stat.in_op)
                        ppi_pkg::OP_LEARN,
                        ppi_pkg::OP_ENCODE: state_next = S_HASH;
                        ppi_pkg::OP_READ:   state_next = S_RDPAL;
                        default:
                        begin
                            kind_next  = ppi_pkg::RES_CLEAR;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                cmd.set_pos = 1'b1;
                state_next  = S_SLOT;
            end
            S_SLOT:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.slot_empty)
                begin
                    state_next = S_DONE;
                    if (stat.op == ppi_pkg::OP_ENCODE)
                        kind_next = ppi_pkg::RES_ABSENT;
                    else if (stat.count_full)
                        kind_next = ppi_pkg::RES_FULL;
                    else
                    begin
                        cmd.insert = 1'b1;
                        kind_next  = ppi_pkg::RES_NEW;
                    end
                end
                else
                begin
                    cmd.pal_from_slot = 1'b1;
                    state_next        = S_MATCH;
                end
            end
            S_MATCH:
            begin
                if (stat.pal_match)
                begin
                    cmd.hit    = 1'b1;
                    kind_next  = (stat.op == ppi_pkg::OP_ENCODE) ?
                                 ppi_pkg::RES_ENC_HIT : ppi_pkg::RES_LEARN_HIT;
                    state_next = S_CODE;
                end
                else if (stat.probe_end)
                begin
                    kind_next  = (stat.op == ppi_pkg::OP_ENCODE) ?
                                 ppi_pkg::RES_ABSENT : ppi_pkg::RES_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step_pos = 1'b1;
                    state_next   = S_SLOT;
                end
            end
            S_CODE:
            begin
                state_next = S_DONE;
            end
            S_RDPAL:
            begin
                kind_next  = stat.range_bad ? ppi_pkg::RES_RANGE : ppi_pkg::RES_READ;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.res_free)
                begin
                    cmd.load_res = 1'b1;
                    if (kind_reg == ppi_pkg::RES_CLEAR)
                    begin
                        cmd.count_clear = 1'b1;
                        state_next      = S_SWEEP;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_SWEEP;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/ppi_dp.sv]
`default_nettype none
module ppi_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ppi_pkg::cmd_t                   cmd,
    output ppi_pkg::stat_t                       stat,
    input  wire logic [1:0]                      opcode,
    input  wire logic [7:0]                      red,
    input  wire logic [7:0]                      green,
    input  wire logic [7:0]                      blue,
    input  wire logic [7:0]                      alpha,
    input  wire logic [ppi_pkg::IDX_W-1:0]       entry_index,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           status,
    output logic                                 is_new,
    output logic [ppi_pkg::IDX_W-1:0]            color_index,
    output logic [23:0]                          color_value,
    output logic                                 is_transparent,
    output logic [1:0]                           code_length,
    output logic [7:0]                           code_first,
    output logic [7:0]                           code_second,
    output logic [7:0]                           code_third,
    output logic [ppi_pkg::COUNT_W-1:0]          palette_count
);

    localparam int SW = ppi_pkg::SLOT_W;
    localparam int IW = ppi_pkg::IDX_W;
    localparam int CW = ppi_pkg::COUNT_W;

    // Composite one channel over white, dividing by 255 with rounding
    function automatic logic [7:0] blend(input logic [7:0] c, input logic [7:0] a);
        logic [16:0] num;
        logic [16:0] sum;
        num = 17'(c * a) + 17'(16'd255 * 16'(8'd255 - a)) + 17'd127;
        sum = num + 17'(num >> 8) + 17'd1;
        return sum[15:8];
    endfunction

    logic [SW-1:0]        hash_mem [0:ppi_pkg::SLOT_COUNT-1];
    logic [ppi_pkg::COLOR_W-1:0] pal_mem [0:ppi_pkg::MAX_COLORS-1];

    ppi_pkg::op_t                op_reg;
    logic [ppi_pkg::COLOR_W-1:0] color_reg;
    logic [IW-1:0]               idx_reg;
    logic [SW-1:0]               pos_reg;
    logic [SW-1:0]               step_reg;
    logic [SW-1:0]               sweep_reg;
    logic [CW-1:0]               count_reg;
    logic [SW-1:0]               slot_q;
    logic [ppi_pkg::COLOR_W-1:0] pal_q;
    logic [5:0]                  quot_reg;
    logic                        out_valid_reg;

    logic [ppi_pkg::COLOR_W-1:0] color_in;
    logic [SW-1:0]               hash_pos;
    logic [2*SW-1:0]             hash_prod;
    logic [IW-1:0]               slot_idx;
    logic [IW-1:0]               pal_addr;
    logic                        hash_we;
    logic [SW-1:0]               hash_waddr;
    logic [SW-1:0]               hash_wdata;
    logic [25:0]                 quot_prod;

    // Composite the incoming pixel
    always_comb
    begin
        if (alpha < 8'd128)
            color_in = 25'h1000000;
        else
            color_in = {1'b0, blend(red, alpha), blend(green, alpha), blend(blue, alpha)};
    end

    // Capture the input word; load the index on a hit or an insert
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= ppi_pkg::op_t'(opcode);
            color_reg <= color_in;
            idx_reg   <= entry_index;
        end
        else if (cmd.hit)
            idx_reg <= slot_idx;
        else if (cmd.insert)
            idx_reg <= count_reg[IW-1:0];
    end

    // Hash start slot and linear probe
    assign hash_prod = color_reg[SW-1:0] * ppi_pkg::HASH_MULT;
    assign hash_pos  = hash_prod[SW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.set_pos)
        begin
            pos_reg  <= hash_pos;
            step_reg <= '0;
        end
        else if (cmd.step_pos)
        begin
            pos_reg  <= pos_reg + 1'b1;
            step_reg <= step_reg + 1'b1;
        end
    end

    // Sweep counter and colour count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.sweep)
                sweep_reg <= sweep_reg + 1'b1;
            if (cmd.count_clear)
                count_reg <= '0;
            else if (cmd.insert)
                count_reg <= count_reg + 1'b1;
        end
    end

    // Hash slot memory
    assign hash_we    = cmd.sweep || cmd.insert;
    assign hash_waddr = cmd.sweep ? sweep_reg : pos_reg;
    assign hash_wdata = cmd.sweep ? '0 : count_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (hash_we)
            hash_mem[hash_waddr] <= hash_wdata;
        slot_q <= hash_mem[pos_reg];
    end

    // Palette memory
    assign slot_idx = IW'(slot_q - 1'b1);
    assign pal_addr = cmd.pal_from_slot ? slot_idx : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
            pal_mem[count_reg[IW-1:0]] <= color_reg;
        pal_q <= pal_mem[pal_addr];
    end

    // Divide the index by 91
    assign quot_prod = idx_reg * ppi_pkg::DIV_RECIP;

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_prod[ppi_pkg::DIV_SHIFT +: 6];
    end

    // Status back to the controller
    always_comb
    begin
        stat.slot_empty = (slot_q == '0);
        stat.pal_match  = (pal_q == color_reg);
        stat.count_full = (count_reg >= CW'(ppi_pkg::MAX_COLORS));
        stat.range_bad  = ({1'b0, idx_reg} >= count_reg);
        stat.probe_end  = (step_reg == SW'(ppi_pkg::SLOT_COUNT - 1));
        stat.sweep_last = (sweep_reg == SW'(ppi_pkg::SLOT_COUNT - 1));
        stat.res_free   = !out_valid_reg || !out_stall;
        stat.op         = op_reg;
        stat.in_op      = ppi_pkg::op_t'(opcode);
    end

    // Build the result word
    logic [ppi_pkg::COLOR_W-1:0] src_color;
    logic [1:0]                  len;
    logic [6:0]                  dig0;
    logic [IW-1:0]               quot_x91;
    logic                        with_code;
    logic                        with_color;
    logic                        with_index;
    logic [1:0]                  res_status;
    logic [CW-1:0]               res_count;

    always_comb
    begin
        src_color = (cmd.res_kind == ppi_pkg::RES_READ) ? pal_q : color_reg;
        if (count_reg <= CW'(ppi_pkg::CODE_RADIX))
            len = 2'd1;
        else if (14'(count_reg) <= 14'(ppi_pkg::CODE_RADIX * ppi_pkg::CODE_RADIX))
            len = 2'd2;
        else
            len = 2'd3;
        quot_x91   = IW'(quot_reg * 7'd91);
        dig0       = 7'(idx_reg - quot_x91);
        with_code  = 1'b0;
        with_color = 1'b1;
        with_index = 1'b0;
        res_status = ppi_pkg::STS_OK;
        res_count  = count_reg;
        case (cmd.res_kind)
            ppi_pkg::RES_LEARN_HIT: with_index = 1'b1;
            ppi_pkg::RES_ENC_HIT:
            begin
                with_index = 1'b1;
                with_code  = 1'b1;
            end
            ppi_pkg::RES_NEW:    with_index = 1'b1;
            ppi_pkg::RES_FULL:   res_status = ppi_pkg::STS_FULL;
            ppi_pkg::RES_ABSENT: res_status = ppi_pkg::STS_ABSENT;
            ppi_pkg::RES_READ:
            begin
                with_index = 1'b1;
                with_code  = 1'b1;
            end
            ppi_pkg::RES_RANGE:
            begin
                res_status = ppi_pkg::STS_RANGE;
                with_color = 1'b0;
            end
            default:
            begin
                with_color = 1'b0;
                res_count  = '0;
            end
        endcase
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_res)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_res)
        begin
            status         <= res_status;
            is_new         <= (cmd.res_kind == ppi_pkg::RES_NEW);
            color_index    <= with_index ? idx_reg : '0;
            color_value    <= (with_color && !src_color[24]) ? src_color[23:0] : 24'd0;
            is_transparent <= with_color && src_color[24];
            code_length    <= with_code ? len : 2'd0;
            code_first     <= with_code ? ppi_pkg::digit_char(dig0) : 8'd0;
            code_second    <= (with_code && len >= 2'd2) ?
                              ppi_pkg::digit_char({1'b0, quot_reg}) : 8'd0;
            code_third     <= (with_code && len == 2'd3) ?
                              ppi_pkg::digit_char(7'd0) : 8'd0;
            palette_count  <= res_count;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[hdl/pixel_palette_indexer.sv]
// Pixel palette indexer: builds a colour palette from RGBA pixels and
// returns palette indices and base-91 pixel codes.
// Input channel: in_valid/in_stall carry opcode, red, green, blue, alpha and
// entry_index. Output channel: out_valid/out_stall carry one result word per
// input word. A word is taken on a rising edge with valid high, stall low.
// One word is worked on at a time. A read fetches the palette entry; a
// learn/encode probes from the first hash slot until an empty slot, the slot
// that holds the colour or the last probe step, passing every occupied slot
// that does not match; each probe step is a slot memory read followed by a
// palette memory read. A clear answers first, then sweeps the 8192 hash
// slots, one a cycle, with in_stall high. After reset the same sweep runs
// before the first word is taken. A result waiting under out_stall is held
// in the output register; the next word may be accepted and worked on, and
// waits only to load its result.
`default_nettype none
module pixel_palette_indexer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  alpha,
    input  wire logic [11:0] entry_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic             is_new,
    output logic [11:0]      color_index,
    output logic [23:0]      color_value,
    output logic             is_transparent,
    output logic [1:0]       code_length,
    output logic [7:0]       code_first,
    output logic [7:0]       code_second,
    output logic [7:0]       code_third,
    output logic [12:0]      palette_count
);

    ppi_pkg::cmd_t  cmd;
    ppi_pkg::stat_t stat;

    ppi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppi_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .entry_index    (entry_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .is_new         (is_new),
        .color_index    (color_index),
        .color_value    (color_value),
        .is_transparent (is_transparent),
        .code_length    (code_length),
        .code_first     (code_first),
        .code_second    (code_second),
        .code_third     (code_third),
        .palette_count  (palette_count)
    );

`ifndef SYNTHESIS
    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_res |-> !(out_valid && out_stall))
        else $error("result register overwritten");

    // Insert only into an empty slot of a palette with room
    a_insert_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (stat.slot_empty && !stat.count_full))
        else $error("insert into occupied slot or full palette");

    // Words are only taken with no sweep running
    a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep |-> in_stall)
        else $error("input taken during slot sweep");

    // A clear leaves an empty palette
    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_clear |=> (palette_count == 13'd0))
        else $error("clear left colours behind");
`endif

endmodule
`default_nettype wire
